// ===== rtl/csi_ap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_ap_pkg
// shared widths, constants, the sideband type and the arctangent step table
// for the subcarrier amplitude / phase pipeline
// ----------------------------------------------------------------------------
package csi_ap_pkg;

  // field widths
  localparam int COMP_W  = 8;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 9;
  localparam int VALUE_W = 8;

  // report shape
  localparam int MAX_SUBCARRIERS = 256;
  localparam int EDGE_NULLS      = 3;
  localparam int CMP_W = 1 + ((CNT_W > $clog2(MAX_SUBCARRIERS + 1)) ?
                              CNT_W : $clog2(MAX_SUBCARRIERS + 1));

  // squared magnitude and root
  localparam int SQ_W    = 2 * COMP_W;
  localparam int ROOT_W  = COMP_W;
  localparam int SQ_LAT  = 2 + ROOT_W;

  // cordic vectoring
  localparam int ITERS   = 24;
  localparam int XF      = 24;
  localparam int XY_W    = XF + 11;
  localparam int AF      = 26;
  localparam int ANG_W   = AF + 3;
  localparam real ANG_SCALE = 2.0 ** AF;
  localparam logic signed [ANG_W-1:0] PI_FX =
    ANG_W'(int'(3.14159265358979323846 * ANG_SCALE));

  // phase scaling: value = floor((100 * t + 320) / 6 * 2) = floor((100t + 320) / 3)
  localparam int PH_MUL     = 100;
  localparam int PH_OFS     = 320;
  localparam int PH_DIV     = 3;
  localparam int NUM_W      = ANG_W + 8;
  localparam int Q_W        = 10;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SH    = 11;
  localparam int PROD_W     = Q_W + 10;
  localparam logic [VALUE_W-1:0] PHASE_AT_ZERO = VALUE_W'(PH_OFS / PH_DIV);

  // pre stage + iterations + post stages
  localparam int POST_LAT = 5;
  localparam int PH_LAT   = 1 + ITERS + POST_LAT;
  localparam int SQ_DLY   = PH_LAT - SQ_LAT;

  // per-item sideband that travels beside the datapath
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic             mode;
    logic             edge_null;
    logic             zero;
  } side_t;

  // atan(2^-i) in AF fractional bits
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] r;
    r = '0;
    unique case (i)
      0:  r = ANG_W'(int'(0.785398163397448310 * ANG_SCALE));
      1:  r = ANG_W'(int'(0.463647609000806116 * ANG_SCALE));
      2:  r = ANG_W'(int'(0.244978663126864154 * ANG_SCALE));
      3:  r = ANG_W'(int'(0.124354994546761435 * ANG_SCALE));
      4:  r = ANG_W'(int'(0.062418809995957348 * ANG_SCALE));
      5:  r = ANG_W'(int'(0.031239833430268277 * ANG_SCALE));
      6:  r = ANG_W'(int'(0.015623728620476830 * ANG_SCALE));
      7:  r = ANG_W'(int'(0.007812341060101111 * ANG_SCALE));
      8:  r = ANG_W'(int'(0.003906230131966972 * ANG_SCALE));
      9:  r = ANG_W'(int'(0.001953122516478819 * ANG_SCALE));
      10: r = ANG_W'(int'(0.000976562189559320 * ANG_SCALE));
      11: r = ANG_W'(int'(0.000488281211194898 * ANG_SCALE));
      12: r = ANG_W'(int'(0.000244140620149362 * ANG_SCALE));
      13: r = ANG_W'(int'(0.000122070311893670 * ANG_SCALE));
      // small angles: atan(2^-i) equals 2^-i to well below one lsb
      default: r = ANG_W'(1) << (AF - i);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/csi_amplitude_phase_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_amplitude_phase_core
// per-subcarrier amplitude or scaled phase of channel-state pairs
// ----------------------------------------------------------------------------
// usage
//   input channel: one subcarrier item per accepted cycle (in_valid_i high,
//   in_stall_o low) with its two signed components, index, report count and
//   last mark. output channel: one result item per input item, in order,
//   taken when out_valid_o is high and out_stall_i is low.
//   cfg_we_i writes the mode bit (1 amplitude, 0 phase) from cfg_wdata_i;
//   write it only while no items are in flight.
//   pipeline: 32 register stages (input register, cordic pre stage, 24
//   cordic iterations, five fold and scale stages, output register).
//   throughput: one item per cycle while no held result stalls the pipeline;
//   the cordic stage chain sets the depth, each stage holds one iteration
//   or one post step.
//   stall: when a result waits and out_stall_i is high the whole pipeline
//   freezes and in_stall_o rises in the same cycle; nothing is dropped.
//   reset: valid bits clear, mode returns to amplitude.
// ----------------------------------------------------------------------------
module csi_amplitude_phase_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_wdata_i,
  // input items
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [csi_ap_pkg::COMP_W-1:0]   first_component_i,
  input  logic signed [csi_ap_pkg::COMP_W-1:0]   second_component_i,
  input  logic        [csi_ap_pkg::IDX_W-1:0]    sub_index_i,
  input  logic        [csi_ap_pkg::CNT_W-1:0]    sub_count_i,
  input  logic                                   last_in_i,
  // result items
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [csi_ap_pkg::IDX_W-1:0]    out_index_o,
  output logic        [csi_ap_pkg::VALUE_W-1:0]  value_o,
  output logic                                   last_out_o
);

  localparam int PH_LAT  = csi_ap_pkg::PH_LAT;
  localparam int SQ_DLY  = csi_ap_pkg::SQ_DLY;
  localparam int CMP_W   = csi_ap_pkg::CMP_W;
  localparam int COMP_W  = csi_ap_pkg::COMP_W;
  localparam int ROOT_W  = csi_ap_pkg::ROOT_W;
  localparam int VALUE_W = csi_ap_pkg::VALUE_W;

  logic adv;
  logic mode_q;

  logic                        valid_q [PH_LAT+1];
  csi_ap_pkg::side_t           side_q  [PH_LAT+1];
  csi_ap_pkg::side_t           side_in;
  logic signed [COMP_W-1:0]    y_q, x_q;

  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  root_dly_q [SQ_DLY];
  logic [VALUE_W-1:0] phase;

  logic                        out_valid_q;
  logic [csi_ap_pkg::IDX_W-1:0] out_index_q;
  logic [VALUE_W-1:0]          value_q, value_d;
  logic                        last_q;

  // pipeline moves unless a finished result is held by the receiver
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // edge subcarrier test against the saturated count
  logic [CMP_W-1:0] idx_ext, cnt_ext, cnt_sat;
  assign idx_ext = CMP_W'(sub_index_i);
  assign cnt_ext = CMP_W'(sub_count_i);
  assign cnt_sat = (cnt_ext > CMP_W'(csi_ap_pkg::MAX_SUBCARRIERS)) ?
                   CMP_W'(csi_ap_pkg::MAX_SUBCARRIERS) : cnt_ext;

  always_comb begin
    side_in.index     = sub_index_i;
    side_in.last      = last_in_i;
    side_in.mode      = mode_q;
    side_in.edge_null = (idx_ext < CMP_W'(csi_ap_pkg::EDGE_NULLS)) ||
                        (idx_ext + CMP_W'(csi_ap_pkg::EDGE_NULLS) >= cnt_sat);
    side_in.zero      = (first_component_i == '0) && (second_component_i == '0);
  end

  // valid bits travel with the items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= PH_LAT; i++) valid_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
      for (int i = 1; i <= PH_LAT; i++) valid_q[i] <= valid_q[i-1];
      out_valid_q <= valid_q[PH_LAT];
    end
  end

  // input register and sideband line
  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q       <= first_component_i;
      x_q       <= second_component_i;
      side_q[0] <= side_in;
      for (int i = 1; i <= PH_LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  csi_ap_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (y_q),
    .b_i    (x_q),
    .root_o (root)
  );

  csi_ap_phase u_phase (
    .clk_i   (clk_i),
    .en_i    (adv),
    .y_i     (y_q),
    .x_i     (x_q),
    .value_o (phase)
  );

  // align the root with the longer phase path
  always_ff @(posedge clk_i) begin
    if (adv) begin
      root_dly_q[0] <= root;
      for (int i = 1; i < SQ_DLY; i++) root_dly_q[i] <= root_dly_q[i-1];
    end
  end

  // result selection
  always_comb begin
    priority if (side_q[PH_LAT].edge_null) begin
      value_d = '0;
    end else if (side_q[PH_LAT].mode) begin
      value_d = VALUE_W'(root_dly_q[SQ_DLY-1]);
    end else if (side_q[PH_LAT].zero) begin
      value_d = csi_ap_pkg::PHASE_AT_ZERO;
    end else begin
      value_d = phase;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_index_q <= side_q[PH_LAT].index;
      value_q     <= value_d;
      last_q      <= side_q[PH_LAT].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign value_o     = value_q;
  assign last_out_o  = last_q;

  // a held result blocks new items in the same cycle
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("held result did not stall the input");

  // edge subcarriers give zero
  a_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && valid_q[PH_LAT] && side_q[PH_LAT].edge_null |=> value_o == '0)
    else $error("edge subcarrier gave a nonzero value");

  // phase results stay inside their range
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && valid_q[PH_LAT] && !side_q[PH_LAT].edge_null && !side_q[PH_LAT].mode
    |=> (value_o >= VALUE_W'(1)) && (value_o <= VALUE_W'(211)))
    else $error("phase value out of range");

  // amplitude results stay inside their range
  a_amp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && valid_q[PH_LAT] && !side_q[PH_LAT].edge_null && side_q[PH_LAT].mode
    |=> value_o <= VALUE_W'(181))
    else $error("amplitude value out of range");

endmodule

// ===== rtl/csi_ap_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_ap_isqrt
// pipelined floor(sqrt(a*a + b*b)): squares, sum, then one root bit per stage
// ----------------------------------------------------------------------------
module csi_ap_isqrt (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic signed [csi_ap_pkg::COMP_W-1:0]      a_i,
  input  logic signed [csi_ap_pkg::COMP_W-1:0]      b_i,
  output logic        [csi_ap_pkg::ROOT_W-1:0]      root_o
);

  localparam int SQ_W   = csi_ap_pkg::SQ_W;
  localparam int ROOT_W = csi_ap_pkg::ROOT_W;

  logic [SQ_W-1:0]   sa_q, sb_q;
  logic [SQ_W-1:0]   s_q [ROOT_W+1];
  logic [ROOT_W-1:0] r_q [ROOT_W+1];

  // squares, then their sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= SQ_W'(a_i * a_i);
      sb_q   <= SQ_W'(b_i * b_i);
      s_q[0] <= sa_q + sb_q;
      r_q[0] <= '0;
    end
  end

  // one root bit per stage, msb first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    logic [ROOT_W-1:0] cand;
    logic [SQ_W-1:0]   cand_sq;
    assign cand    = r_q[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
    assign cand_sq = SQ_W'(cand) * SQ_W'(cand);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k+1] <= s_q[k];
        r_q[k+1] <= (cand_sq <= s_q[k]) ? cand : r_q[k];
      end
    end
  end

  assign root_o = r_q[ROOT_W];

endmodule

// ===== rtl/csi_ap_phase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_ap_phase
// pipelined scaled phase: quadrant fold, cordic vectoring one iteration per
// stage, unfold to the full circle, then floor((100*t + 320) / 3)
// ----------------------------------------------------------------------------
module csi_ap_phase (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic signed [csi_ap_pkg::COMP_W-1:0]      y_i,
  input  logic signed [csi_ap_pkg::COMP_W-1:0]      x_i,
  output logic        [csi_ap_pkg::VALUE_W-1:0]     value_o
);

  localparam int COMP_W = csi_ap_pkg::COMP_W;
  localparam int ITERS  = csi_ap_pkg::ITERS;
  localparam int XF     = csi_ap_pkg::XF;
  localparam int XY_W   = csi_ap_pkg::XY_W;
  localparam int AF     = csi_ap_pkg::AF;
  localparam int ANG_W  = csi_ap_pkg::ANG_W;
  localparam int NUM_W  = csi_ap_pkg::NUM_W;
  localparam int Q_W    = csi_ap_pkg::Q_W;
  localparam int PROD_W = csi_ap_pkg::PROD_W;
  localparam int VALUE_W = csi_ap_pkg::VALUE_W;

  localparam logic signed [NUM_W-1:0] OFS_FX =
    NUM_W'(csi_ap_pkg::PH_OFS) <<< AF;

  logic signed [XY_W-1:0]  cx_q [ITERS+1];
  logic signed [XY_W-1:0]  cy_q [ITERS+1];
  logic signed [ANG_W-1:0] cz_q [ITERS+1];
  logic                    xneg_q [ITERS+1];
  logic                    yneg_q [ITERS+1];

  logic [COMP_W-1:0] ax, ay;

  // magnitudes into the first quadrant
  assign ax = x_i[COMP_W-1] ? COMP_W'(-x_i) : COMP_W'(x_i);
  assign ay = y_i[COMP_W-1] ? COMP_W'(-y_i) : COMP_W'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0]   <= $signed({{(XY_W-COMP_W-XF){1'b0}}, ax, {XF{1'b0}}});
      cy_q[0]   <= $signed({{(XY_W-COMP_W-XF){1'b0}}, ay, {XF{1'b0}}});
      cz_q[0]   <= '0;
      xneg_q[0] <= x_i[COMP_W-1];
      yneg_q[0] <= y_i[COMP_W-1];
    end
  end

  // vectoring iterations drive y toward zero and collect the angle
  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam logic signed [ANG_W-1:0] ATAN_I = csi_ap_pkg::atan_step(i);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy_q[i][XY_W-1]) begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + ATAN_I;
        end else begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - ATAN_I;
        end
        xneg_q[i+1] <= xneg_q[i];
        yneg_q[i+1] <= yneg_q[i];
      end
    end
  end

  logic signed [ANG_W-1:0] phi_q, t_q;
  logic                    yneg_p1_q;
  logic signed [NUM_W-1:0] num_q;
  logic [Q_W-1:0]          q_q;
  logic [PROD_W-1:0]       prod;
  logic [VALUE_W-1:0]      value_q;

  assign prod = PROD_W'(q_q) * PROD_W'(csi_ap_pkg::DIV3_MUL);

  // unfold to the full circle, scale and offset, floor by 2^AF then by 3
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi_q     <= xneg_q[ITERS] ? (csi_ap_pkg::PI_FX - cz_q[ITERS]) : cz_q[ITERS];
      yneg_p1_q <= yneg_q[ITERS];
      t_q       <= yneg_p1_q ? -phi_q : phi_q;
      num_q     <= NUM_W'(t_q) * NUM_W'(csi_ap_pkg::PH_MUL) + OFS_FX;
      q_q       <= num_q[NUM_W-1] ? '0 : num_q[AF +: Q_W];
      value_q   <= prod[csi_ap_pkg::DIV3_SH +: VALUE_W];
    end
  end

  assign value_o = value_q;

endmodule

// ===== tb/csi_amplitude_phase_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_amplitude_phase_core_test
// self-checking bench for the subcarrier amplitude / phase core: a short
// table of hand-picked items, then random report fragments and noise under
// three idle patterns, every result compared against a bit-exact predictor
// ----------------------------------------------------------------------------
module csi_amplitude_phase_core_test;

  localparam int COMP_W  = csi_ap_pkg::COMP_W;
  localparam int IDX_W   = csi_ap_pkg::IDX_W;
  localparam int CNT_W   = csi_ap_pkg::CNT_W;
  localparam int VALUE_W = csi_ap_pkg::VALUE_W;

  // angle arithmetic of the predictor: radians with 48 fractional bits
  localparam int      ANG_FRAC   = 48;
  localparam longint  ANG_PI_Q48 = 64'sd884279719003555;
  localparam int      ATAN_TERMS = 40;

  localparam logic MODE_PHASE     = 1'b0;
  localparam logic MODE_AMPLITUDE = 1'b1;

  localparam int SETTLE_CYCLES = 64;
  localparam int TIMEOUT_NS    = 4_000_000;

  typedef struct {
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] x;
    logic [IDX_W-1:0]         idx;
    logic [CNT_W-1:0]         cnt;
    logic                     last;
  } sub_item_t;

  typedef struct {
    logic [IDX_W-1:0]   index;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

  typedef struct {
    logic               mode;
    sub_item_t          item;
    bit                 known;
    logic [VALUE_W-1:0] value;
  } table_row_t;

  // dut signals
  logic                     clk_i              = 1'b0;
  logic                     rst_ni             = 1'b0;
  logic                     cfg_we_i           = 1'b0;
  logic                     cfg_wdata_i        = 1'b0;
  logic                     in_valid_i         = 1'b0;
  logic                     in_stall_o;
  logic signed [COMP_W-1:0] first_component_i  = '0;
  logic signed [COMP_W-1:0] second_component_i = '0;
  logic [IDX_W-1:0]         sub_index_i        = '0;
  logic [CNT_W-1:0]         sub_count_i        = '0;
  logic                     last_in_i          = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i        = 1'b0;
  logic [IDX_W-1:0]         out_index_o;
  logic [VALUE_W-1:0]       value_o;
  logic                     last_out_o;

  // bench state
  result_t    pending_results[$];
  table_row_t stim_table[$];
  logic       mode_shadow    = MODE_AMPLITUDE;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         errors_seen    = 0;

  csi_amplitude_phase_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .first_component_i  (first_component_i),
    .second_component_i (second_component_i),
    .sub_index_i        (sub_index_i),
    .sub_count_i        (sub_count_i),
    .last_in_i          (last_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_index_o        (out_index_o),
    .value_o            (value_o),
    .last_out_o         (last_out_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // integer square root, floor
  function automatic int unsigned root_floor(input int unsigned s);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    return r;
  endfunction

  // atan(num/den) for 0 <= num <= den/2 by power series
  function automatic longint arctan_series(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned num_sq;
    longint unsigned den_sq;
    longint unsigned pw;
    longint          acc;
    longint          term;
    num_sq = num * num;
    den_sq = den * den;
    pw     = (num << ANG_FRAC) / den;
    acc    = 0;
    for (int k = 0; k < ATAN_TERMS; k++) begin
      term = longint'(pw / longint'(unsigned'(2 * k + 1)));
      acc  = (k % 2 == 1) ? acc - term : acc + term;
      pw   = pw * num_sq / den_sq;
    end
    return acc;
  endfunction

  // atan(n/d) for 0 <= n <= d, folded about pi/4
  function automatic longint arctan_octant(input longint unsigned n,
                                           input longint unsigned d);
    if (2 * n <= d) return arctan_series(n, d);
    return (ANG_PI_Q48 >>> 2) - arctan_series(d - n, d + n);
  endfunction

  // floor(200 * (atan2(y, x) + 3.2) / 6), angle zero when both are zero
  function automatic logic [VALUE_W-1:0] scaled_phase(input logic signed [COMP_W-1:0] y,
                                                      input logic signed [COMP_W-1:0] x);
    int              yi;
    int              xi;
    longint unsigned ay;
    longint unsigned ax;
    longint          phi;
    longint          angle;
    longint          num;
    yi = int'(y);
    xi = int'(x);
    ay = longint'(yi < 0 ? -yi : yi);
    ax = longint'(xi < 0 ? -xi : xi);
    if (ay == 0 && ax == 0) begin
      angle = 0;
    end else begin
      if (ay <= ax) phi = arctan_octant(ay, ax);
      else phi = (ANG_PI_Q48 >>> 1) - arctan_octant(ax, ay);
      angle = (xi >= 0) ? phi : ANG_PI_Q48 - phi;
      if (yi < 0) angle = -angle;
    end
    num = 100 * angle + (longint'(320) <<< ANG_FRAC);
    if (num < 0) num = 0;
    return VALUE_W'(num / (longint'(3) <<< ANG_FRAC));
  endfunction

  // value of one subcarrier: edge nulls, then amplitude or phase
  function automatic logic [VALUE_W-1:0] subcarrier_value(input logic mode,
                                                          input sub_item_t it);
    int cnt_sat;
    int idx;
    int yi;
    int xi;
    cnt_sat = (it.cnt > csi_ap_pkg::MAX_SUBCARRIERS) ? csi_ap_pkg::MAX_SUBCARRIERS : it.cnt;
    idx     = int'(it.idx);
    yi      = int'(it.y);
    xi      = int'(it.x);
    if (idx < csi_ap_pkg::EDGE_NULLS || idx + csi_ap_pkg::EDGE_NULLS >= cnt_sat) return '0;
    if (mode == MODE_AMPLITUDE) return VALUE_W'(root_floor(yi * yi + xi * xi));
    return scaled_phase(it.y, it.x);
  endfunction

  // random component, weighted toward the extremes, zero and small values
  function automatic logic signed [COMP_W-1:0] pick_component();
    unique case ($urandom_range(7))
      0: return -8'sd128;
      1: return 8'sd127;
      2: return '0;
      3: return COMP_W'($urandom_range(6)) - 8'sd3;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  // present one item, wait for its acceptance, record what it should give
  task automatic send_item(input sub_item_t it, input bit known,
                           input logic [VALUE_W-1:0] known_value);
    result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    first_component_i  <= it.y;
    second_component_i <= it.x;
    sub_index_i        <= it.idx;
    sub_count_i        <= it.cnt;
    last_in_i          <= it.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want.index = it.idx;
    want.value = known ? known_value : subcarrier_value(mode_shadow, it);
    want.last  = it.last;
    pending_results.push_back(want);
  endtask

  // drain the pipeline, then write the mode bit
  task automatic set_mode(input logic m);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_shadow  = m;
  endtask

  task automatic add_row(input logic mode, input int y, input int x, input int idx,
                         input int cnt, input logic last, input bit known,
                         input int value);
    table_row_t row;
    row.mode      = mode;
    row.item.y    = COMP_W'(y);
    row.item.x    = COMP_W'(x);
    row.item.idx  = IDX_W'(idx);
    row.item.cnt  = CNT_W'(cnt);
    row.item.last = last;
    row.known     = known;
    row.value     = VALUE_W'(value);
    stim_table.push_back(row);
  endtask

  // mostly well-formed report fragments with random content, some noise
  task automatic run_random(input int n_items);
    int        sent;
    int        cnt;
    int        first;
    int        len;
    sub_item_t it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(7) == 0) begin
          // saturated count, fragment at the top edge
          cnt   = $urandom_range(256, 511);
          first = $urandom_range(236, 250);
        end else begin
          cnt   = $urandom_range(6, 40);
          first = 0;
        end
        len = ((cnt > csi_ap_pkg::MAX_SUBCARRIERS) ? csi_ap_pkg::MAX_SUBCARRIERS : cnt) - first;
        for (int i = 0; i < len && sent < n_items; i++) begin
          it.y    = pick_component();
          it.x    = pick_component();
          it.idx  = IDX_W'(first + i);
          it.cnt  = CNT_W'(cnt);
          it.last = (i == len - 1);
          send_item(it, 1'b0, '0);
          sent++;
        end
      end else begin
        it.y    = COMP_W'($urandom);
        it.x    = COMP_W'($urandom);
        it.idx  = IDX_W'($urandom);
        it.cnt  = CNT_W'($urandom_range(511));
        it.last = 1'($urandom_range(1));
        send_item(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver: random stall, compare each result item with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation, index %0d value %0d", out_index_o, value_o);
        errors_seen++;
      end else begin
        want = pending_results.pop_front();
        if (out_index_o !== want.index) begin
          $error("out_index: expected %0d, got %0d", want.index, out_index_o);
          errors_seen++;
        end
        if (value_o !== want.value) begin
          $error("value: expected %0d, got %0d (index %0d)", want.value, value_o, want.index);
          errors_seen++;
        end
        if (last_out_o !== want.last) begin
          $error("last_out: expected %0d, got %0d", want.last, last_out_o);
          errors_seen++;
        end
      end
    end
  end

  // main sequence
  initial begin : main_seq
    logic cur_mode;
    cur_mode = MODE_AMPLITUDE;

    // amplitude rows: extremes, saturation, edges, index past count
    add_row(MODE_AMPLITUDE,    0,    0,  10,  64, 1'b0, 1'b1,   0);
    add_row(MODE_AMPLITUDE,    3,    4,  10,  64, 1'b0, 1'b1,   5);
    add_row(MODE_AMPLITUDE, -128, -128, 100, 256, 1'b0, 1'b1, 181);
    add_row(MODE_AMPLITUDE,  127,  127, 128, 300, 1'b0, 1'b1, 179);
    add_row(MODE_AMPLITUDE, -128,  127, 255, 511, 1'b1, 1'b1,   0);
    add_row(MODE_AMPLITUDE,   50,  -60,   0,  64, 1'b0, 1'b1,   0);
    add_row(MODE_AMPLITUDE,   50,  -60,   2,  64, 1'b0, 1'b1,   0);
    add_row(MODE_AMPLITUDE,   50,  -60,   3,  64, 1'b0, 1'b0,   0);
    add_row(MODE_AMPLITUDE,  -77,   91,  60,  64, 1'b0, 1'b0,   0);
    add_row(MODE_AMPLITUDE,  -77,   91,  61,  64, 1'b1, 1'b1,   0);
    add_row(MODE_AMPLITUDE,   40,   40,  20,  10, 1'b0, 1'b1,   0);
    add_row(MODE_AMPLITUDE,   40,   40,   5,   0, 1'b0, 1'b1,   0);
    add_row(MODE_AMPLITUDE,   -1,   -1, 252, 300, 1'b0, 1'b1,   1);
    add_row(MODE_AMPLITUDE,   -1,   -1, 253, 300, 1'b1, 1'b1,   0);
    // phase rows: zero pair, axes, both sides of the branch cut
    add_row(MODE_PHASE,    0,    0,  10,  64, 1'b0, 1'b1, 106);
    add_row(MODE_PHASE,    0,  127,  11,  64, 1'b0, 1'b1, 106);
    add_row(MODE_PHASE,    0, -128,  12,  64, 1'b0, 1'b1, 211);
    add_row(MODE_PHASE,    5,    0,  13,  64, 1'b0, 1'b1, 159);
    add_row(MODE_PHASE,   -5,    0,  14,  64, 1'b0, 1'b1,  54);
    add_row(MODE_PHASE,   -1, -128,  15,  64, 1'b0, 1'b0,   0);
    add_row(MODE_PHASE,    1, -128,  16,  64, 1'b0, 1'b0,   0);
    add_row(MODE_PHASE, -128,  127,  17,  64, 1'b0, 1'b0,   0);
    add_row(MODE_PHASE,  127, -128, 128, 256, 1'b0, 1'b0,   0);
    add_row(MODE_PHASE,   77,  -33,   1,  64, 1'b0, 1'b1,   0);
    add_row(MODE_PHASE,  -90,   45, 200, 256, 1'b1, 1'b0,   0);

    send_idle_pct  = 32;
    recv_stall_pct = 76;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, mode rewritten whenever a row asks for another one
    set_mode(MODE_AMPLITUDE);
    foreach (stim_table[i]) begin
      if (stim_table[i].mode != cur_mode) begin
        set_mode(stim_table[i].mode);
        cur_mode = stim_table[i].mode;
      end
      send_item(stim_table[i].item, stim_table[i].known, stim_table[i].value);
    end

    // random part under three idle patterns, both modes each
    for (int pat = 0; pat < 3; pat++) begin
      unique case (pat)
        0: begin send_idle_pct = 32; recv_stall_pct = 76; end
        1: begin send_idle_pct = 76; recv_stall_pct = 32; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      set_mode(MODE_PHASE);
      run_random(88);
      set_mode(MODE_AMPLITUDE);
      run_random(88);
    end

    // wait for the last results, then a little longer
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (errors_seen == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== csi_amplitude_phase_core.f =====
rtl/csi_ap_pkg.sv
rtl/csi_ap_isqrt.sv
rtl/csi_ap_phase.sv
rtl/csi_amplitude_phase_core.sv
tb/csi_amplitude_phase_core_test.sv
